// File: rtl/bmls_pkg.sv
// ============================================================================
// bmls_pkg - shared types and codes of the byte data memory
// Item structs, operation, size and status codes, controller command/status.
// ============================================================================
`default_nettype none

package bmls_pkg;

  // operation codes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_STORE = 2'd2;

  // access sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_LOAD_HIT   = 2'd1;
  localparam logic [1:0] STATUS_STORE_BUSY = 2'd2;

  // reset value of the store latency register
  localparam logic [7:0] TPS_RESET = 8'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] byte_address;
    logic [1:0]  access_size;
    logic        sign_extend;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic        busy_now;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear;    // write zero to the current clear row
    logic accept;   // input transfer this cycle
    logic advance;  // move stage 1 into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // clear row counter on its final row
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/bmls_ram.sv
// ============================================================================
// bmls_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module bmls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bmls_ctrl.sv
// ============================================================================
// bmls_ctrl - controller of the byte data memory
// Runs the clearing pass after reset, then steers the two-stage result pipe.
// ============================================================================
`default_nettype none

module bmls_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire bmls_pkg::stat_t stat,
  output bmls_pkg::cmd_t      cmd
);

  import bmls_pkg::*;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  state_t state;
  logic   s1_valid;
  logic   s1_adv;

  assign s1_adv      = !out_valid || out_ready;
  assign in_ready    = (state == ST_RUN) && (!s1_valid || s1_adv);
  assign cmd.clear   = (state == ST_CLEAR);
  assign cmd.accept  = in_valid && in_ready;
  assign cmd.advance = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: if (stat.clear_last) state <= ST_RUN;
        ST_RUN:   state <= ST_RUN;
        default:  state <= ST_CLEAR;
      endcase
      s1_valid <= cmd.accept || (s1_valid && !cmd.advance);
      if (cmd.advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_rose_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.advance))
    else $error("result shown without a stage 1 advance");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> s1_valid)
    else $error("accepted item lost before stage 1");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("stage 1 dropped while output stalled");

  a_clear_stay: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && !stat.clear_last) |=> (state == ST_CLEAR))
    else $error("clearing pass left early");

endmodule

`default_nettype wire

// File: rtl/bmls_dp.sv
// ============================================================================
// bmls_dp - datapath of the byte data memory
// Four byte banks, busy/tick/pending state, load formatting and output reg.
// ============================================================================
`default_nettype none

module bmls_dp #(
  parameter int ADDRESS_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bmls_pkg::cmd_t      cmd,
  output bmls_pkg::stat_t          stat,
  input  wire bmls_pkg::in_item_t  in_data,
  output bmls_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata
);

  import bmls_pkg::*;

  localparam int AW    = ADDRESS_BITS;
  localparam int RW    = AW - 2;
  localparam int ROWS  = 1 << RW;
  localparam int PW    = (AW < 16) ? AW : 16;

  // architectural state
  logic [7:0]    tps;
  logic          busy;
  logic [7:0]    tick_count;
  logic [PW-1:0] pending;
  logic [RW-1:0] clr_row;

  // decode of the incoming item
  logic [31:0]   addr32;
  logic [AW-1:0] start;
  logic [1:0]    off;
  logic [RW-1:0] arow;
  logic          is_tick, is_load, is_store;
  logic          store_ok, load_hit, load_rd;
  logic [7:0]    tick_inc;
  logic          busy_next;
  logic [1:0]    status_now;

  // stage 1
  logic       s1_rd;
  logic [1:0] s1_off;
  logic [1:0] s1_size;
  logic       s1_sext;
  logic [1:0] s1_status;
  logic       s1_busy;

  logic [7:0]  bank_q [4];
  logic [7:0]  rb     [4];
  logic [31:0] rv;

  assign addr32   = {16'b0, in_data.byte_address};
  assign start    = addr32[AW-1:0];
  assign off      = start[1:0];
  assign arow     = start[AW-1:2];
  assign is_tick  = (in_data.mode == MODE_TICK);
  assign is_load  = (in_data.mode == MODE_LOAD);
  assign is_store = (in_data.mode == MODE_STORE);
  assign store_ok = is_store && !busy;
  assign load_hit = is_load && busy && (start[PW-1:0] == pending);
  assign load_rd  = is_load && !load_hit;
  assign tick_inc = tick_count + 8'd1;

  assign stat.clear_last = (clr_row == {RW{1'b1}});

  always_comb begin
    busy_next = busy;
    if (is_tick && busy && (tick_inc == tps)) begin
      busy_next = 1'b0;
    end else if (store_ok) begin
      busy_next = 1'b1;
    end
    if (load_hit) begin
      status_now = STATUS_LOAD_HIT;
    end else if (is_store && busy) begin
      status_now = STATUS_STORE_BUSY;
    end else begin
      status_now = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tps        <= TPS_RESET;
      busy       <= 1'b0;
      tick_count <= 8'd0;
      pending    <= '0;
      clr_row    <= '0;
    end else begin
      if (cfg_we) begin
        tps <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_row <= clr_row + RW'(1);
      end
      if (cmd.accept) begin
        busy <= busy_next;
        if (is_tick && busy) begin
          tick_count <= (tick_inc == tps) ? 8'd0 : tick_inc;
        end else if (store_ok) begin
          tick_count <= 8'd0;
          pending    <= start[PW-1:0];
        end
      end
    end
  end

  // byte banks: bank b holds addresses with low bits b
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BANK = 2'(b);
    logic [1:0]    lane;
    logic [RW-1:0] row;
    logic          lane_on;
    logic [7:0]    wbyte;

    assign lane  = BANK - off;
    assign row   = arow + RW'(BANK < off);
    assign wbyte = 8'(in_data.write_value >> {lane, 3'b000});

    always_comb begin
      case (in_data.access_size)
        SIZE_BYTE: lane_on = (lane == 2'd0);
        SIZE_HALF: lane_on = !lane[1];
        SIZE_WORD: lane_on = 1'b1;
        default:   lane_on = 1'b0;
      endcase
    end

    bmls_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (cmd.clear || (cmd.accept && store_ok && lane_on)),
      .waddr(cmd.clear ? clr_row : row),
      .wdata(cmd.clear ? 8'd0 : wbyte),
      .re   (cmd.accept && load_rd),
      .raddr(row),
      .rdata(bank_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s1_rd     <= load_rd;
      s1_off    <= off;
      s1_size   <= in_data.access_size;
      s1_sext   <= in_data.sign_extend;
      s1_status <= status_now;
      s1_busy   <= busy_next;
    end
    if (cmd.advance) begin
      out_data.read_value <= rv;
      out_data.status     <= s1_status;
      out_data.busy_now   <= s1_busy;
    end
  end

  // rotate bank outputs back into byte order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rb[i] = bank_q[2'(s1_off + 2'(i))];
    end
    case (s1_size)
      SIZE_BYTE: rv = {{24{s1_sext & rb[0][7]}}, rb[0]};
      SIZE_HALF: rv = {{16{s1_sext & rb[1][7]}}, rb[1], rb[0]};
      SIZE_WORD: rv = {rb[3], rb[2], rb[1], rb[0]};
      default:   rv = 32'd0;
    endcase
    if (!s1_rd) begin
      rv = 32'd0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/byte_memory_load_store_with_latency_top.sv
// ============================================================================
// byte_memory_load_store_with_latency_top - byte data memory with store busy
// Little-endian byte/half/word loads and stores over four byte banks.
// ============================================================================
// Pipeline: an input transfer loads stage 1 (bank read data, item fields),
//   which moves into the output register once it is free. Throughput: one
//   item per cycle unless the output stalls, set by each bank's single access.
// Reset: rst clears control state, then a clearing pass zeroes one row of all
//   four banks per cycle over all 2**(ADDRESS_BITS-2) rows (16384 by default);
//   in_ready stays low during it, configuration writes are still taken.
`default_nettype none

module byte_memory_load_store_with_latency_top #(
  parameter int ADDRESS_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // input item channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bmls_pkg::in_item_t  in_data,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bmls_pkg::out_item_t      out_data,
  // ticks_per_store register write
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata
);

  import bmls_pkg::*;

  // command and status between controller and datapath
  cmd_t  cmd;
  stat_t stat;

  // Controller: hold the input off while clearing, advance the pipe,
  // and transfer results out as the consumer allows.
  bmls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: banks, busy tick count, pending address compare, formatting.
  bmls_dp #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

endmodule

`default_nettype wire
